### rtl/tpm_pkg.sv
`default_nettype none

package tpm_pkg;

    localparam int QUEUE_DEPTH_DEF = 8;

    localparam int TIME_W  = 63;
    localparam int TAG_W   = 16;
    localparam int DELTA_W = 40;
    localparam int MODE_W  = 2;

    localparam logic [DELTA_W-1:0] MAX_DELTA_RESET = 40'd10000000;

    localparam logic [MODE_W-1:0] MODE_COLOUR = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DEPTH  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_PAIR   = 2'd2;
    localparam logic [MODE_W-1:0] MODE_FLUSH  = 2'd3;

    typedef struct packed {
        logic [TIME_W-1:0] ts;
        logic [TAG_W-1:0]  tag;
    } entry_t;

    typedef enum logic [2:0] {
        Q_NOP,
        Q_PUSH,
        Q_FLUSH,
        Q_READ,
        Q_REMOVE
    } q_op_t;

    typedef struct packed {
        q_op_t  op;
        entry_t entry;
    } q_req_t;

    typedef enum logic [1:0] {
        QS_IDLE,
        QS_RD,
        QS_WR
    } q_state_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOP,
        S_SCAN,
        S_EVAL,
        S_HEADS,
        S_RM_C,
        S_RM_D,
        S_DONE
    } tpm_state_t;

endpackage

`default_nettype wire

### rtl/tpm_ram.sv
`default_nettype none

module tpm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  wire logic                                clk,
    input  wire logic                                we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                    wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                    rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### rtl/tpm_queue.sv
`default_nettype none

module tpm_queue #(
    parameter int QUEUE_DEPTH = tpm_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire tpm_pkg::q_req_t        req,
    input  wire logic [((QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1)-1:0] idx,
    output logic [$clog2(QUEUE_DEPTH + 1)-1:0] count,
    output tpm_pkg::entry_t             rdata,
    output logic                        busy
);

    localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [IDX_W:0]   DEPTH_X = (IDX_W + 1)'(QUEUE_DEPTH);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);

    tpm_pkg::q_state_t state_reg, state_next;
    logic [IDX_W-1:0]  head_reg, head_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [IDX_W-1:0]  i_reg, i_next;

    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic [IDX_W-1:0]  raddr;
    logic [IDX_W-1:0]  rd_off;
    logic [IDX_W-1:0]  i_inc;
    tpm_pkg::entry_t   wdata;
    logic              full;

    // logical position to memory address in the ring
    function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] base,
                                                  input logic [IDX_W-1:0] off);
        logic [IDX_W:0] s;
        s = {1'b0, base} + {1'b0, off};
        if (s >= DEPTH_X)
        begin
            s = s - DEPTH_X;
        end
        return s[IDX_W-1:0];
    endfunction

    assign full   = (count_reg == DEPTH_C);
    assign i_inc  = i_reg + IDX_W'(1);
    assign rd_off = (state_reg == tpm_pkg::QS_RD) ? i_inc : idx;
    assign raddr  = wrap_add(head_reg, rd_off);

    always_comb
    begin
        state_next = state_reg;
        head_next  = head_reg;
        count_next = count_reg;
        i_next     = i_reg;
        we         = 1'b0;
        waddr      = wrap_add(head_reg, i_reg);
        wdata      = req.entry;
        unique case (state_reg)
            tpm_pkg::QS_IDLE:
            begin
                unique case (req.op)
                    tpm_pkg::Q_PUSH:
                    begin
                        we    = 1'b1;
                        waddr = wrap_add(head_reg, full ? IDX_W'(0) : count_reg[IDX_W-1:0]);
                        if (full)
                        begin
                            head_next = wrap_add(head_reg, IDX_W'(1));
                        end
                        else
                        begin
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                    tpm_pkg::Q_FLUSH:
                    begin
                        count_next = '0;
                    end
                    tpm_pkg::Q_REMOVE:
                    begin
                        if (CNT_W'(idx) < count_reg)
                        begin
                            if (idx == '0)
                            begin
                                head_next  = wrap_add(head_reg, IDX_W'(1));
                                count_next = count_reg - CNT_W'(1);
                            end
                            else if (CNT_W'(idx) + CNT_W'(1) >= count_reg)
                            begin
                                count_next = count_reg - CNT_W'(1);
                            end
                            else
                            begin
                                i_next     = idx;
                                state_next = tpm_pkg::QS_RD;
                            end
                        end
                    end
                    tpm_pkg::Q_READ, tpm_pkg::Q_NOP:
                    begin
                    end
                    default:
                    begin
                    end
                endcase
            end
            tpm_pkg::QS_RD:
            begin
                state_next = tpm_pkg::QS_WR;
            end
            tpm_pkg::QS_WR:
            begin
                // move the later entry down by one slot
                we     = 1'b1;
                waddr  = wrap_add(head_reg, i_reg);
                wdata  = rdata;
                i_next = i_inc;
                if (CNT_W'(i_reg) + CNT_W'(2) < count_reg)
                begin
                    state_next = tpm_pkg::QS_RD;
                end
                else
                begin
                    count_next = count_reg - CNT_W'(1);
                    state_next = tpm_pkg::QS_IDLE;
                end
            end
            default:
            begin
                state_next = tpm_pkg::QS_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tpm_pkg::QS_IDLE;
            head_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg <= i_next;
    end

    tpm_ram #(
        .WIDTH ($bits(tpm_pkg::entry_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign count = count_reg;
    assign busy  = (state_reg != tpm_pkg::QS_IDLE);

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_C)
        else $error("queue count above depth");

    a_shift_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != tpm_pkg::QS_IDLE) |-> (CNT_W'(i_reg) + CNT_W'(1) < count_reg))
        else $error("shift index past last entry");

    a_shift_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tpm_pkg::QS_RD) |=> $stable(count_reg))
        else $error("count changed in the middle of a shift");

endmodule

`default_nettype wire

### rtl/timestamp_pair_matcher_unit.sv
// colour arrival, depth arrival and flush: busy stays low, no result
// pair request: it ends when a queue is found empty, else each round scans all Cc*Cd pairs (Cc/Cd the
// fill levels), one pair per cycle, then a stale drop starts the next round; a match removes both
// entries, shifting later entries down by one slot, and ends it, as does a stop with no stale head
// done strobes once per pair request, in the same cycle that busy drops; the receiver cannot stall it
// reset: both queues empty (memories not cleared), max_delta_ns = 10000000
`default_nettype none

module timestamp_pair_matcher_unit #(
    parameter int QUEUE_DEPTH = tpm_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic [tpm_pkg::MODE_W-1:0]   mode,
    input  wire logic [tpm_pkg::TAG_W-1:0]    frame_tag,
    input  wire logic [tpm_pkg::TIME_W-1:0]   arrival_time_ns,
    input  wire logic                         cfg_we,
    input  wire logic [tpm_pkg::DELTA_W-1:0]  cfg_wdata,
    output logic                              done,
    output logic                              paired,
    output logic [tpm_pkg::TAG_W-1:0]         colour_tag,
    output logic [tpm_pkg::TAG_W-1:0]         depth_tag,
    output logic [tpm_pkg::DELTA_W-1:0]       pair_delta_ns
);

    localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int TW    = tpm_pkg::TIME_W;

    tpm_pkg::tpm_state_t state_reg, state_next;
    logic [tpm_pkg::DELTA_W-1:0] max_delta_reg, max_delta_next;

    logic             iss_act_reg, iss_act_next;
    logic [IDX_W-1:0] iss_ci_reg, iss_ci_next;
    logic [IDX_W-1:0] iss_di_reg, iss_di_next;
    logic             p1_valid_reg, p1_valid_next;
    logic [IDX_W-1:0] p1_ci_reg, p1_ci_next;
    logic [IDX_W-1:0] p1_di_reg, p1_di_next;
    logic             p2_valid_reg, p2_valid_next;
    logic [IDX_W-1:0] p2_ci_reg, p2_ci_next;
    logic [IDX_W-1:0] p2_di_reg, p2_di_next;
    logic [TW-1:0]    diff_reg, diff_next;
    logic [tpm_pkg::TAG_W-1:0] p2_ctag_reg, p2_ctag_next;
    logic [tpm_pkg::TAG_W-1:0] p2_dtag_reg, p2_dtag_next;

    logic             found_reg, found_next;
    logic [TW-1:0]    best_reg, best_next;
    logic [IDX_W-1:0] bc_reg, bc_next;
    logic [IDX_W-1:0] bd_reg, bd_next;
    logic [tpm_pkg::TAG_W-1:0] best_ctag_reg, best_ctag_next;
    logic [tpm_pkg::TAG_W-1:0] best_dtag_reg, best_dtag_next;

    logic                        done_reg, done_next;
    logic                        res_paired_reg, res_paired_next;
    logic [tpm_pkg::TAG_W-1:0]   res_ctag_reg, res_ctag_next;
    logic [tpm_pkg::TAG_W-1:0]   res_dtag_reg, res_dtag_next;
    logic [tpm_pkg::DELTA_W-1:0] res_delta_reg, res_delta_next;

    tpm_pkg::q_req_t  c_req, d_req;
    logic [IDX_W-1:0] c_idx, d_idx;
    logic [CNT_W-1:0] c_count, d_count;
    tpm_pkg::entry_t  c_rdata, d_rdata;
    logic             c_busy, d_busy;
    tpm_pkg::entry_t  in_entry;

    logic [CNT_W-1:0] c_cm1, d_cm1;
    logic [IDX_W-1:0] c_last, d_last;
    logic [TW:0]      sub_ab, sub_ba;
    logic [TW-1:0]    abs_diff;
    logic [TW:0]      sum_c, sum_d;
    logic             c_stale, d_stale;

    assign in_entry = '{ts: arrival_time_ns, tag: frame_tag};
    assign c_cm1    = c_count - CNT_W'(1);
    assign d_cm1    = d_count - CNT_W'(1);
    assign c_last   = c_cm1[IDX_W-1:0];
    assign d_last   = d_cm1[IDX_W-1:0];

    assign sub_ab   = {1'b0, c_rdata.ts} - {1'b0, d_rdata.ts};
    assign sub_ba   = {1'b0, d_rdata.ts} - {1'b0, c_rdata.ts};
    assign abs_diff = sub_ab[TW] ? sub_ba[TW-1:0] : sub_ab[TW-1:0];

    // head stale tests, the sum cannot overflow 64 bits
    assign sum_c   = {1'b0, c_rdata.ts} + (TW + 1)'(max_delta_reg);
    assign sum_d   = {1'b0, d_rdata.ts} + (TW + 1)'(max_delta_reg);
    assign c_stale = sum_c < {1'b0, d_rdata.ts};
    assign d_stale = sum_d < {1'b0, c_rdata.ts};

    assign busy = (state_reg != tpm_pkg::S_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        max_delta_next  = cfg_we ? cfg_wdata : max_delta_reg;
        iss_act_next    = iss_act_reg;
        iss_ci_next     = iss_ci_reg;
        iss_di_next     = iss_di_reg;
        p1_valid_next   = 1'b0;
        p1_ci_next      = iss_ci_reg;
        p1_di_next      = iss_di_reg;
        p2_valid_next   = p1_valid_reg;
        p2_ci_next      = p1_ci_reg;
        p2_di_next      = p1_di_reg;
        diff_next       = abs_diff;
        p2_ctag_next    = c_rdata.tag;
        p2_dtag_next    = d_rdata.tag;
        found_next      = found_reg;
        best_next       = best_reg;
        bc_next         = bc_reg;
        bd_next         = bd_reg;
        best_ctag_next  = best_ctag_reg;
        best_dtag_next  = best_dtag_reg;
        done_next       = (state_reg == tpm_pkg::S_DONE);
        res_paired_next = res_paired_reg;
        res_ctag_next   = res_ctag_reg;
        res_dtag_next   = res_dtag_reg;
        res_delta_next  = res_delta_reg;
        c_req           = '{op: tpm_pkg::Q_NOP, entry: in_entry};
        d_req           = '{op: tpm_pkg::Q_NOP, entry: in_entry};
        c_idx           = '0;
        d_idx           = '0;

        unique case (state_reg)
            tpm_pkg::S_IDLE:
            begin
                if (start)
                begin
                    priority if (mode == tpm_pkg::MODE_COLOUR)
                    begin
                        c_req.op = tpm_pkg::Q_PUSH;
                    end
                    else if (mode == tpm_pkg::MODE_DEPTH)
                    begin
                        d_req.op = tpm_pkg::Q_PUSH;
                    end
                    else if (mode == tpm_pkg::MODE_FLUSH)
                    begin
                        c_req.op = tpm_pkg::Q_FLUSH;
                        d_req.op = tpm_pkg::Q_FLUSH;
                    end
                    else
                    begin
                        res_paired_next = 1'b0;
                        res_ctag_next   = '0;
                        res_dtag_next   = '0;
                        res_delta_next  = '0;
                        state_next      = tpm_pkg::S_LOOP;
                    end
                end
            end
            tpm_pkg::S_LOOP:
            begin
                if (c_count == '0 || d_count == '0)
                begin
                    state_next = tpm_pkg::S_DONE;
                end
                else
                begin
                    iss_act_next = 1'b1;
                    iss_ci_next  = '0;
                    iss_di_next  = '0;
                    found_next   = 1'b0;
                    state_next   = tpm_pkg::S_SCAN;
                end
            end
            tpm_pkg::S_SCAN:
            begin
                // read issue, memory read, difference, compare
                c_req.op      = tpm_pkg::Q_READ;
                d_req.op      = tpm_pkg::Q_READ;
                c_idx         = iss_ci_reg;
                d_idx         = iss_di_reg;
                p1_valid_next = iss_act_reg;
                if (iss_act_reg)
                begin
                    if (iss_di_reg == d_last)
                    begin
                        iss_di_next = '0;
                        if (iss_ci_reg == c_last)
                        begin
                            iss_act_next = 1'b0;
                        end
                        else
                        begin
                            iss_ci_next = iss_ci_reg + IDX_W'(1);
                        end
                    end
                    else
                    begin
                        iss_di_next = iss_di_reg + IDX_W'(1);
                    end
                end
                // strict compare keeps the first pair in scan order on a tie
                if (p2_valid_reg && (!found_reg || diff_reg < best_reg))
                begin
                    found_next     = 1'b1;
                    best_next      = diff_reg;
                    bc_next        = p2_ci_reg;
                    bd_next        = p2_di_reg;
                    best_ctag_next = p2_ctag_reg;
                    best_dtag_next = p2_dtag_reg;
                end
                if (!iss_act_reg && !p1_valid_reg && !p2_valid_reg)
                begin
                    state_next = tpm_pkg::S_EVAL;
                end
            end
            tpm_pkg::S_EVAL:
            begin
                if (found_reg && best_reg <= TW'(max_delta_reg))
                begin
                    res_paired_next = 1'b1;
                    res_ctag_next   = best_ctag_reg;
                    res_dtag_next   = best_dtag_reg;
                    res_delta_next  = best_reg[tpm_pkg::DELTA_W-1:0];
                    c_req.op        = tpm_pkg::Q_REMOVE;
                    c_idx           = bc_reg;
                    state_next      = tpm_pkg::S_RM_C;
                end
                else
                begin
                    c_req.op   = tpm_pkg::Q_READ;
                    d_req.op   = tpm_pkg::Q_READ;
                    state_next = tpm_pkg::S_HEADS;
                end
            end
            tpm_pkg::S_HEADS:
            begin
                priority if (c_stale)
                begin
                    c_req.op   = tpm_pkg::Q_REMOVE;
                    state_next = tpm_pkg::S_LOOP;
                end
                else if (d_stale)
                begin
                    d_req.op   = tpm_pkg::Q_REMOVE;
                    state_next = tpm_pkg::S_LOOP;
                end
                else
                begin
                    state_next = tpm_pkg::S_DONE;
                end
            end
            tpm_pkg::S_RM_C:
            begin
                if (!c_busy)
                begin
                    d_req.op   = tpm_pkg::Q_REMOVE;
                    d_idx      = bd_reg;
                    state_next = tpm_pkg::S_RM_D;
                end
            end
            tpm_pkg::S_RM_D:
            begin
                if (!d_busy)
                begin
                    state_next = tpm_pkg::S_DONE;
                end
            end
            tpm_pkg::S_DONE:
            begin
                state_next = tpm_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tpm_pkg::S_IDLE;
            max_delta_reg <= tpm_pkg::MAX_DELTA_RESET;
            iss_act_reg   <= 1'b0;
            p1_valid_reg  <= 1'b0;
            p2_valid_reg  <= 1'b0;
            found_reg     <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            max_delta_reg <= max_delta_next;
            iss_act_reg   <= iss_act_next;
            p1_valid_reg  <= p1_valid_next;
            p2_valid_reg  <= p2_valid_next;
            found_reg     <= found_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        iss_ci_reg     <= iss_ci_next;
        iss_di_reg     <= iss_di_next;
        p1_ci_reg      <= p1_ci_next;
        p1_di_reg      <= p1_di_next;
        p2_ci_reg      <= p2_ci_next;
        p2_di_reg      <= p2_di_next;
        diff_reg       <= diff_next;
        p2_ctag_reg    <= p2_ctag_next;
        p2_dtag_reg    <= p2_dtag_next;
        best_reg       <= best_next;
        bc_reg         <= bc_next;
        bd_reg         <= bd_next;
        best_ctag_reg  <= best_ctag_next;
        best_dtag_reg  <= best_dtag_next;
        res_paired_reg <= res_paired_next;
        res_ctag_reg   <= res_ctag_next;
        res_dtag_reg   <= res_dtag_next;
        res_delta_reg  <= res_delta_next;
    end

    tpm_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_colour_q (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (c_req),
        .idx   (c_idx),
        .count (c_count),
        .rdata (c_rdata),
        .busy  (c_busy)
    );

    tpm_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_depth_q (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (d_req),
        .idx   (d_idx),
        .count (d_count),
        .rdata (d_rdata),
        .busy  (d_busy)
    );

    assign done          = done_reg;
    assign paired        = res_paired_reg;
    assign colour_tag    = res_ctag_reg;
    assign depth_tag     = res_dtag_reg;
    assign pair_delta_ns = res_delta_reg;

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    a_unpaired_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !paired) |-> (colour_tag == '0 && depth_tag == '0 && pair_delta_ns == '0))
        else $error("unpaired item carries nonzero fields");

    a_request_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && mode == tpm_pkg::MODE_PAIR) |=> (busy && !done))
        else $error("pair request not taken up");

    a_scan_queues_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tpm_pkg::S_SCAN) |-> (!c_busy && !d_busy))
        else $error("scan overlaps a queue shift");

endmodule

`default_nettype wire

### tb/sv/timestamp_pair_matcher_unit_test.sv
`default_nettype none

module timestamp_pair_matcher_unit_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TIME_W  = tpm_pkg::TIME_W;
    localparam int TAG_W   = tpm_pkg::TAG_W;
    localparam int DELTA_W = tpm_pkg::DELTA_W;
    localparam int MODE_W  = tpm_pkg::MODE_W;

    localparam int DEPTH = tpm_pkg::QUEUE_DEPTH_DEF;
    localparam int ITEMS_PER_PHASE = 190;
    localparam int NUM_PHASES = 5;
    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
    localparam logic [DELTA_W-1:0] DELTA_MAX = {DELTA_W{1'b1}};

    typedef struct packed {
        logic               paired;
        logic [TAG_W-1:0]   ctag;
        logic [TAG_W-1:0]   dtag;
        logic [DELTA_W-1:0] delta;
    } pair_result_t;

    class pair_scoreboard;
        logic [TIME_W-1:0]  colour_stamps[$];
        logic [TAG_W-1:0]   colour_tags[$];
        logic [TIME_W-1:0]  depth_stamps[$];
        logic [TAG_W-1:0]   depth_tags[$];
        logic [DELTA_W-1:0] max_delta;
        pair_result_t       expected_pairs[$];
        int                 mismatches;
        int                 items_noted;
        int                 results_checked;
        int                 results_matched;

        function new();
            max_delta = tpm_pkg::MAX_DELTA_RESET;
            mismatches = 0;
            items_noted = 0;
            results_checked = 0;
            results_matched = 0;
        endfunction

        function int pending();
            return expected_pairs.size();
        endfunction

        // nearest pair wins, otherwise drop a stale head and rescan
        function pair_result_t match_pair();
            pair_result_t r;
            logic [63:0] a;
            logic [63:0] b;
            logic [63:0] d;
            logic [63:0] best;
            int bc;
            int bd;
            bit found;
            r = '0;
            while (colour_stamps.size() > 0 && depth_stamps.size() > 0)
            begin
                found = 0;
                best = '0;
                bc = 0;
                bd = 0;
                for (int ci = 0; ci < colour_stamps.size(); ci++)
                begin
                    for (int di = 0; di < depth_stamps.size(); di++)
                    begin
                        a = 64'(colour_stamps[ci]);
                        b = 64'(depth_stamps[di]);
                        d = (a > b) ? a - b : b - a;
                        if (!found || d < best)
                        begin
                            found = 1;
                            best = d;
                            bc = ci;
                            bd = di;
                        end
                    end
                end
                if (found && best <= 64'(max_delta))
                begin
                    r.paired = 1'b1;
                    r.ctag = colour_tags[bc];
                    r.dtag = depth_tags[bd];
                    r.delta = best[DELTA_W-1:0];
                    colour_stamps.delete(bc);
                    colour_tags.delete(bc);
                    depth_stamps.delete(bd);
                    depth_tags.delete(bd);
                    return r;
                end
                if (64'(colour_stamps[0]) + 64'(max_delta) < 64'(depth_stamps[0]))
                begin
                    colour_stamps.delete(0);
                    colour_tags.delete(0);
                end
                else if (64'(depth_stamps[0]) + 64'(max_delta) < 64'(colour_stamps[0]))
                begin
                    depth_stamps.delete(0);
                    depth_tags.delete(0);
                end
                else
                    break;
            end
            return r;
        endfunction

        function void note_item(logic [MODE_W-1:0] m, logic [TAG_W-1:0] tag,
                                logic [TIME_W-1:0] ts);
            items_noted++;
            unique case (m)
                tpm_pkg::MODE_COLOUR:
                begin
                    if (colour_stamps.size() >= DEPTH)
                    begin
                        colour_stamps.delete(0);
                        colour_tags.delete(0);
                    end
                    colour_stamps.insert(colour_stamps.size(), ts);
                    colour_tags.insert(colour_tags.size(), tag);
                end
                tpm_pkg::MODE_DEPTH:
                begin
                    if (depth_stamps.size() >= DEPTH)
                    begin
                        depth_stamps.delete(0);
                        depth_tags.delete(0);
                    end
                    depth_stamps.insert(depth_stamps.size(), ts);
                    depth_tags.insert(depth_tags.size(), tag);
                end
                tpm_pkg::MODE_PAIR:
                    expected_pairs.insert(expected_pairs.size(), match_pair());
                tpm_pkg::MODE_FLUSH:
                begin
                    colour_stamps.delete();
                    colour_tags.delete();
                    depth_stamps.delete();
                    depth_tags.delete();
                end
            endcase
        endfunction

        function void compare_field(string name, logic [DELTA_W-1:0] exp_v,
                                    logic [DELTA_W-1:0] act_v);
            if (exp_v !== act_v)
            begin
                $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                         $time, name, exp_v, act_v);
                mismatches++;
            end
        endfunction

        function void check_result(logic p, logic [TAG_W-1:0] ct, logic [TAG_W-1:0] dt,
                                   logic [DELTA_W-1:0] dl);
            pair_result_t exp_r;
            if (expected_pairs.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %0b/%0h/%0h/%0h",
                         $time, p, ct, dt, dl);
                mismatches++;
                return;
            end
            exp_r = expected_pairs[0];
            expected_pairs.delete(0);
            results_checked++;
            if (exp_r.paired)
                results_matched++;
            compare_field("paired", DELTA_W'(exp_r.paired), DELTA_W'(p));
            compare_field("colour_tag", DELTA_W'(exp_r.ctag), DELTA_W'(ct));
            compare_field("depth_tag", DELTA_W'(exp_r.dtag), DELTA_W'(dt));
            compare_field("pair_delta_ns", exp_r.delta, dl);
        endfunction
    endclass

    logic                clk = 1'b0;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic [MODE_W-1:0]   mode;
    logic [TAG_W-1:0]    frame_tag;
    logic [TIME_W-1:0]   arrival_time_ns;
    logic                cfg_we;
    logic [DELTA_W-1:0]  cfg_wdata;
    logic                done;
    logic                paired;
    logic [TAG_W-1:0]    colour_tag;
    logic [TAG_W-1:0]    depth_tag;
    logic [DELTA_W-1:0]  pair_delta_ns;

    pair_scoreboard      sb;
    logic [TIME_W-1:0]   time_base;
    int                  limits_used;

    timestamp_pair_matcher_unit #(
        .QUEUE_DEPTH(DEPTH)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .mode(mode),
        .frame_tag(frame_tag),
        .arrival_time_ns(arrival_time_ns),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata),
        .done(done),
        .paired(paired),
        .colour_tag(colour_tag),
        .depth_tag(depth_tag),
        .pair_delta_ns(pair_delta_ns)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && done === 1'b1)
            sb.check_result(paired, colour_tag, depth_tag, pair_delta_ns);
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // arrival times cluster around a drifting base, scaled to the current limit
    function automatic logic [TIME_W-1:0] next_arrival_ns();
        int r;
        logic [63:0] span;
        logic [TIME_W-1:0] t;
        r = $urandom_range(0, 99);
        span = 2 * 64'(sb.max_delta) + 2;
        if (r < 4)
            return '0;
        if (r < 8)
            return TIME_MAX;
        if (r < 20)
            return TIME_W'(rand64());
        t = time_base + TIME_W'(rand64() % span);
        time_base = time_base + TIME_W'(rand64() % (64'(sb.max_delta) / 2 + 2));
        return t;
    endfunction

    task automatic send_item(input logic [MODE_W-1:0] m, input logic [TAG_W-1:0] tag,
                             input logic [TIME_W-1:0] ts, input int idle_pct);
        int gap;
        gap = 0;
        if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
            gap = $urandom_range(1, 6);
        @(negedge clk);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start <= 1'b1;
        mode <= m;
        frame_tag <= tag;
        arrival_time_ns <= ts;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        sb.note_item(m, tag, ts);
    endtask

    task automatic drain();
        @(negedge clk);
        start <= 1'b0;
        while (sb.pending() > 0)
            @(posedge clk);
        // arrivals and flushes leave no result to wait for, so idle on afterwards
        repeat (8) @(posedge clk);
    endtask

    task automatic write_limit(input logic [DELTA_W-1:0] v);
        drain();
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
        sb.max_delta = v;
        limits_used++;
    endtask

    task automatic random_phase(input int n, input int idle_pct);
        int r;
        logic [MODE_W-1:0] m;
        logic [TAG_W-1:0] tag;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 31)
                m = tpm_pkg::MODE_COLOUR;
            else if (r < 62)
                m = tpm_pkg::MODE_DEPTH;
            else if (r < 97)
                m = tpm_pkg::MODE_PAIR;
            else
                m = tpm_pkg::MODE_FLUSH;
            tag = TAG_W'($urandom_range(0, 65535));
            send_item(m, tag, next_arrival_ns(), idle_pct);
        end
    endtask

    initial
    begin
        #10_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        logic [DELTA_W-1:0] phase_limit[NUM_PHASES];
        int phase_idle[NUM_PHASES];
        sb = new();
        limits_used = 1;
        time_base = TIME_W'(rand64());
        rst_n = 1'b0;
        start = 1'b0;
        mode = tpm_pkg::MODE_COLOUR;
        frame_tag = '0;
        arrival_time_ns = '0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed items at the reset limit
        send_item(tpm_pkg::MODE_PAIR, TAG_W'($urandom), TIME_W'(rand64()), 0);
        send_item(tpm_pkg::MODE_COLOUR, 16'hFFFF, '0, 0);
        send_item(tpm_pkg::MODE_PAIR, TAG_W'($urandom), TIME_W'(rand64()), 0);
        // difference exactly at the limit still pairs
        send_item(tpm_pkg::MODE_DEPTH, 16'h0000, TIME_W'(tpm_pkg::MAX_DELTA_RESET), 0);
        send_item(tpm_pkg::MODE_PAIR, TAG_W'($urandom), TIME_W'(rand64()), 0);
        // widest possible gap: depth head stale, then depth queue empty
        send_item(tpm_pkg::MODE_COLOUR, 16'h0000, TIME_MAX, 0);
        send_item(tpm_pkg::MODE_DEPTH, 16'hFFFF, '0, 0);
        send_item(tpm_pkg::MODE_PAIR, TAG_W'($urandom), TIME_W'(rand64()), 0);
        send_item(tpm_pkg::MODE_FLUSH, TAG_W'($urandom), TIME_W'(rand64()), 0);
        send_item(tpm_pkg::MODE_PAIR, TAG_W'($urandom), TIME_W'(rand64()), 0);
        // overfill the colour queue, then a tie between two colour entries
        for (int i = 1; i <= DEPTH + 1; i++)
            send_item(tpm_pkg::MODE_COLOUR, TAG_W'(i), TIME_W'(100 * i), 0);
        send_item(tpm_pkg::MODE_DEPTH, 16'h00AA, TIME_W'(250), 0);
        send_item(tpm_pkg::MODE_PAIR, TAG_W'($urandom), TIME_W'(rand64()), 0);
        // every colour head goes stale one after another
        send_item(tpm_pkg::MODE_DEPTH, 16'h5555,
                  TIME_W'(tpm_pkg::MAX_DELTA_RESET) + TIME_W'(901), 0);
        send_item(tpm_pkg::MODE_PAIR, TAG_W'($urandom), TIME_W'(rand64()), 0);
        send_item(tpm_pkg::MODE_FLUSH, TAG_W'($urandom), TIME_W'(rand64()), 0);

        phase_limit[0] = '0;
        phase_limit[1] = DELTA_MAX;
        phase_limit[2] = DELTA_W'($urandom_range(1, 100000));
        phase_limit[3] = tpm_pkg::MAX_DELTA_RESET;
        phase_limit[4] = {8'($urandom_range(0, 255)), 32'($urandom)};
        phase_idle[0] = 0;
        phase_idle[1] = 49;
        phase_idle[2] = 0;
        phase_idle[3] = 16;
        phase_idle[4] = 49;
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            write_limit(phase_limit[p]);
            random_phase(ITEMS_PER_PHASE, phase_idle[p]);
        end
        drain();

        $display("ran %0d items over %0d limit settings, including zero and full scale",
                 sb.items_noted, limits_used);
        $display("checked %0d pair results, %0d of them paired, %0d mismatches",
                 sb.results_checked, sb.results_matched, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

`default_nettype wire

### sim.f
rtl/tpm_pkg.sv
rtl/tpm_ram.sv
rtl/tpm_queue.sv
rtl/timestamp_pair_matcher_unit.sv
tb/sv/timestamp_pair_matcher_unit_test.sv
